### rtl/dsc_pkg.sv
// Shared widths, word types and helpers for the directed segment crossing test.
`default_nettype none
package dsc_pkg;

  localparam int CW            = 32;  // coordinate width
  localparam int DFW           = CW + 1;  // coordinate difference width
  localparam int PW            = 2 * DFW;  // product of two differences
  localparam int SW            = PW + 1;  // sum of two products
  localparam int DW            = SW;  // divider numerator and denominator width
  localparam int MW            = DFW;  // multiplier bits walked by the divider
  localparam int MD_LAT        = MW + 1;  // divider latency, rounding stage included
  localparam int UN_FRAC       = 14;  // Q2.14 normal
  localparam int UN_STEPS      = UN_FRAC + 1;
  localparam int UN_BITS       = UN_FRAC + 1;
  localparam int UN_SHIFT      = 2 * UN_FRAC + 2;
  localparam int UW            = PW + UN_SHIFT + 4;  // running width of the normal search
  localparam int NOW           = 16;  // unit normal output width
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] wall_a_x;
    logic signed [CW-1:0] wall_a_y;
    logic signed [CW-1:0] wall_b_x;
    logic signed [CW-1:0] wall_b_y;
  } in_word_t;

  typedef struct packed {
    logic                  hit;
    logic signed [CW-1:0]  cross_x;
    logic signed [CW-1:0]  cross_y;
    logic signed [CW-1:0]  fraction;
    logic signed [NOW-1:0] unit_normal_x;
    logic signed [NOW-1:0] unit_normal_y;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0]  sx;
    logic signed [CW-1:0]  sy;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  bx;
    logic signed [CW-1:0]  by;
    logic signed [DFW-1:0] nx;
    logic signed [DFW-1:0] ny;
    logic                  dx_neg;
    logic                  dy_neg;
    logic                  keep;
  } side_t;

  typedef struct packed {
    logic [UN_BITS-1:0] qx;
    logic [UN_BITS-1:0] qy;
    logic               x_neg;
    logic               y_neg;
  } un_res_t;

  function automatic logic signed [DFW-1:0] ext_c(input logic signed [CW-1:0] v);
    return DFW'(v);
  endfunction

endpackage
`default_nettype wire

### rtl/dsc_if.sv
// Valid/ready channel interfaces for the segment and result words.
`default_nettype none
interface dsc_in_if;
  import dsc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dsc_out_if;
  import dsc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/dsc_muldiv.sv
// Pipelined fused multiply-divide: round(num * mul / den), one multiplier bit per stage.
`default_nettype none
module dsc_muldiv (
  input  wire logic                  clk,
  input  wire logic                  adv,
  input  wire logic [dsc_pkg::DW-1:0] num,
  input  wire logic [dsc_pkg::DW-1:0] den,
  input  wire logic [dsc_pkg::MW-1:0] mul,
  output logic      [dsc_pkg::MW-1:0] quot
);
  import dsc_pkg::*;

  logic [DW-1:0] rem_r [MW];
  logic [MW-1:0] q_r   [MW];
  logic [DW-1:0] num_r [MW];
  logic [DW-1:0] den_r [MW];
  logic [MW-1:0] m_r   [MW];
  logic [MW-1:0] quot_r;

  // Remainder stays below den while num <= den, so each digit is 0, 1 or 2.
  for (genvar i = 0; i < MW; i++) begin : g_st
    logic [DW-1:0]   rem_w, num_w, den_w;
    logic [MW-1:0]   q_w, m_w;
    logic [DW+1:0]   s_w, d1x_w, d2x_w;
    if (i == 0) begin : g_first
      assign rem_w = '0;
      assign q_w   = '0;
      assign num_w = num;
      assign den_w = den;
      assign m_w   = mul;
    end else begin : g_next
      assign rem_w = rem_r[i-1];
      assign q_w   = q_r[i-1];
      assign num_w = num_r[i-1];
      assign den_w = den_r[i-1];
      assign m_w   = m_r[i-1];
    end
    assign s_w   = {1'b0, rem_w, 1'b0} + (m_w[MW-1-i] ? (DW+2)'(num_w) : '0);
    assign d1x_w = (DW+2)'(den_w);
    assign d2x_w = {1'b0, den_w, 1'b0};

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[i] <= num_w;
        den_r[i] <= den_w;
        m_r[i]   <= m_w;
        if (s_w >= d2x_w) begin
          rem_r[i] <= DW'(s_w - d2x_w);
          q_r[i]   <= MW'({q_w, 1'b0}) + MW'(2);
        end else if (s_w >= d1x_w) begin
          rem_r[i] <= DW'(s_w - d1x_w);
          q_r[i]   <= MW'({q_w, 1'b0}) + MW'(1);
        end else begin
          rem_r[i] <= DW'(s_w);
          q_r[i]   <= MW'({q_w, 1'b0});
        end
      end
    end
  end

  // Round half up on the final remainder.
  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r <= q_r[MW-1] + MW'({rem_r[MW-1], 1'b0} >= {1'b0, den_r[MW-1]});
    end
  end

  assign quot = quot_r;

endmodule
`default_nettype wire

### rtl/directed_segment_crossing_test_top.sv
// Directed segment crossing test: motion segment against wall segment, fully pipelined.
// Usage:
//   in_ch carries one word per item: motion start and end, wall vertices A and B,
//   all signed fixed point with COORD_FRAC_BITS fraction bits.
//   out_ch returns one word per item: hit flag, crossing point, crossing fraction
//   and the unit wall normal in Q2.14; every field but hit reads zero on a miss.
// Timing:
//   One word is accepted every cycle unless the output stalls; the depth is set by the
//   fused multiply-divide units, which walk one of 33 multiplier bits per stage.
// Reset:
//   rst_n clears every valid bit; the pipeline comes out of reset empty and ready.
// Back-pressure:
//   While out_ch.ready is low and a result waits, the whole pipeline holds and
//   in_ch.ready drops, even where slots further up the pipe are empty.
`default_nettype none
module directed_segment_crossing_test_top #(
  parameter int COORD_FRAC_BITS = dsc_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dsc_in_if.sink   in_ch,
  dsc_out_if.source out_ch
);
  import dsc_pkg::*;

  localparam int NST    = 3 + MD_LAT + 4;
  localparam int UN_DLY = MD_LAT + 3 - UN_STEPS;
  localparam logic [MW-1:0] FRAC_ONE = MW'(1) << COORD_FRAC_BITS;

  logic           adv;
  logic [NST-1:0] v_r;
  in_word_t       iw;

  assign iw          = in_ch.data;
  assign adv         = out_ch.ready | ~v_r[NST-1];
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_ch.valid};
    end
  end

  // Stage 1: differences.
  logic signed [DFW-1:0] s1_nx_r, s1_ny_r, s1_sax_r, s1_say_r, s1_eax_r, s1_eay_r;
  logic signed [DFW-1:0] s1_ebx_r, s1_eby_r, s1_dx_r, s1_dy_r;
  logic signed [CW-1:0]  s1_sx_r, s1_sy_r, s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_nx_r  <= ext_c(iw.wall_a_y) - ext_c(iw.wall_b_y);
      s1_ny_r  <= ext_c(iw.wall_b_x) - ext_c(iw.wall_a_x);
      s1_sax_r <= ext_c(iw.start_x) - ext_c(iw.wall_a_x);
      s1_say_r <= ext_c(iw.start_y) - ext_c(iw.wall_a_y);
      s1_eax_r <= ext_c(iw.end_x) - ext_c(iw.wall_a_x);
      s1_eay_r <= ext_c(iw.end_y) - ext_c(iw.wall_a_y);
      s1_ebx_r <= ext_c(iw.wall_b_x) - ext_c(iw.end_x);
      s1_eby_r <= ext_c(iw.wall_b_y) - ext_c(iw.end_y);
      s1_dx_r  <= ext_c(iw.end_x) - ext_c(iw.start_x);
      s1_dy_r  <= ext_c(iw.end_y) - ext_c(iw.start_y);
      s1_sx_r  <= iw.start_x;
      s1_sy_r  <= iw.start_y;
      s1_ax_r  <= iw.wall_a_x;
      s1_ay_r  <= iw.wall_a_y;
      s1_bx_r  <= iw.wall_b_x;
      s1_by_r  <= iw.wall_b_y;
    end
  end

  // Stage 2: products. The wall direction B-A equals (ny, -nx).
  logic signed [PW-1:0]  s2_d1a_r, s2_d1b_r, s2_d2a_r, s2_d2b_r;
  logic signed [PW-1:0]  s2_ea_r, s2_eb_r, s2_fa_r, s2_fb_r, s2_nxx_r, s2_nyy_r;
  logic signed [DFW-1:0] s2_nx_r, s2_ny_r, s2_dx_r, s2_dy_r;
  logic signed [CW-1:0]  s2_sx_r, s2_sy_r, s2_ax_r, s2_ay_r, s2_bx_r, s2_by_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d1a_r <= s1_nx_r * s1_sax_r;
      s2_d1b_r <= s1_ny_r * s1_say_r;
      s2_d2a_r <= s1_nx_r * s1_eax_r;
      s2_d2b_r <= s1_ny_r * s1_eay_r;
      s2_ea_r  <= s1_eax_r * s1_ny_r;
      s2_eb_r  <= s1_eay_r * s1_nx_r;
      s2_fa_r  <= s1_ebx_r * s1_ny_r;
      s2_fb_r  <= s1_eby_r * s1_nx_r;
      s2_nxx_r <= s1_nx_r * s1_nx_r;
      s2_nyy_r <= s1_ny_r * s1_ny_r;
      s2_nx_r  <= s1_nx_r;
      s2_ny_r  <= s1_ny_r;
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_sx_r  <= s1_sx_r;
      s2_sy_r  <= s1_sy_r;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_bx_r  <= s1_bx_r;
      s2_by_r  <= s1_by_r;
    end
  end

  // Stage 3: sums.
  logic signed [SW-1:0]  s3_d1_r, s3_d2_r, s3_ea_r, s3_eb_r;
  logic signed [SW:0]    s3_den_r;
  logic [PW-1:0]         s3_n2_r, s3_nxx_r, s3_nyy_r;
  logic signed [DFW-1:0] s3_nx_r, s3_ny_r, s3_dx_r, s3_dy_r;
  logic signed [CW-1:0]  s3_sx_r, s3_sy_r, s3_ax_r, s3_ay_r, s3_bx_r, s3_by_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_d1_r  <= SW'(s2_d1a_r) + SW'(s2_d1b_r);
      s3_d2_r  <= SW'(s2_d2a_r) + SW'(s2_d2b_r);
      s3_den_r <= (SW+1)'(s2_d1a_r) + (SW+1)'(s2_d1b_r)
                - (SW+1)'(s2_d2a_r) - (SW+1)'(s2_d2b_r);
      s3_ea_r  <= SW'(s2_ea_r) - SW'(s2_eb_r);
      s3_eb_r  <= SW'(s2_fa_r) - SW'(s2_fb_r);
      s3_n2_r  <= s2_nxx_r + s2_nyy_r;
      s3_nxx_r <= s2_nxx_r;
      s3_nyy_r <= s2_nyy_r;
      s3_nx_r  <= s2_nx_r;
      s3_ny_r  <= s2_ny_r;
      s3_dx_r  <= s2_dx_r;
      s3_dy_r  <= s2_dy_r;
      s3_sx_r  <= s2_sx_r;
      s3_sy_r  <= s2_sy_r;
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_bx_r  <= s2_bx_r;
      s3_by_r  <= s2_by_r;
    end
  end

  // Front-to-back test, degenerate cases and the end point projection.
  side_t         side_w;
  logic [MW-1:0] mag_dx_w, mag_dy_w;

  assign side_w.sx     = s3_sx_r;
  assign side_w.sy     = s3_sy_r;
  assign side_w.ax     = s3_ax_r;
  assign side_w.ay     = s3_ay_r;
  assign side_w.bx     = s3_bx_r;
  assign side_w.by     = s3_by_r;
  assign side_w.nx     = s3_nx_r;
  assign side_w.ny     = s3_ny_r;
  assign side_w.dx_neg = s3_dx_r[DFW-1];
  assign side_w.dy_neg = s3_dy_r[DFW-1];
  assign side_w.keep   = !s3_d1_r[SW-1]
                       && !(s3_d1_r != '0 && !s3_d2_r[SW-1] && s3_d2_r != '0)
                       && s3_den_r != '0 && !s3_ea_r[SW-1] && !s3_eb_r[SW-1];

  assign mag_dx_w = s3_dx_r[DFW-1] ? MW'(-s3_dx_r) : MW'(s3_dx_r);
  assign mag_dy_w = s3_dy_r[DFW-1] ? MW'(-s3_dy_r) : MW'(s3_dy_r);

  logic [MW-1:0] qx_w, qy_w, qf_w;

  dsc_muldiv u_mdx (
    .clk (clk), .adv (adv), .num (s3_d1_r[DW-1:0]), .den (s3_den_r[DW-1:0]),
    .mul (mag_dx_w), .quot (qx_w)
  );
  dsc_muldiv u_mdy (
    .clk (clk), .adv (adv), .num (s3_d1_r[DW-1:0]), .den (s3_den_r[DW-1:0]),
    .mul (mag_dy_w), .quot (qy_w)
  );
  dsc_muldiv u_mdf (
    .clk (clk), .adv (adv), .num (s3_d1_r[DW-1:0]), .den (s3_den_r[DW-1:0]),
    .mul (FRAC_ONE), .quot (qf_w)
  );

  side_t side_dly_r [MD_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly_r[0] <= side_w;
      for (int k = 1; k < MD_LAT; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
    end
  end

  // Unit normal: largest q with n2 * (2q-1)^2 <= c^2 * 2^30, one bit per stage.
  // rem = R - n2*(2q-1)^2 and p = n2*(2q-1) are kept so each step is adds only.
  logic signed [UW-1:0]  un_rem_r [UN_STEPS][2];
  logic signed [UW-1:0]  un_p_r   [UN_STEPS][2];
  logic [UN_BITS-1:0]    un_q_r   [UN_STEPS][2];
  logic                  un_neg_r [UN_STEPS][2];
  logic [PW-1:0]         un_n2_r  [UN_STEPS];

  for (genvar i = 0; i < UN_STEPS; i++) begin : g_un
    logic [PW-1:0] n2_w;
    if (i == 0) begin : g_n2_first
      assign n2_w = s3_n2_r;
    end else begin : g_n2_next
      assign n2_w = un_n2_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        un_n2_r[i] <= n2_w;
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_c
      logic signed [UW-1:0] rem_w, p_w, t_w;
      logic [UN_BITS-1:0]   q_w;
      logic                 neg_w;
      if (i == 0) begin : g_first
        assign rem_w = (UW'(j == 0 ? s3_nxx_r : s3_nyy_r) << UN_SHIFT) - UW'(n2_w);
        assign p_w   = -UW'(n2_w);
        assign q_w   = '0;
        assign neg_w = (j == 0) ? s3_nx_r[DFW-1] : s3_ny_r[DFW-1];
      end else begin : g_next
        assign rem_w = un_rem_r[i-1][j];
        assign p_w   = un_p_r[i-1][j];
        assign q_w   = un_q_r[i-1][j];
        assign neg_w = un_neg_r[i-1][j];
      end
      assign t_w = rem_w - (p_w <<< (UN_STEPS + 1 - i))
                 - (UW'(n2_w) << (2 * (UN_STEPS - 1 - i) + 2));

      always_ff @(posedge clk) begin
        if (adv) begin
          un_neg_r[i][j] <= neg_w;
          if (!t_w[UW-1]) begin
            un_rem_r[i][j] <= t_w;
            un_p_r[i][j]   <= p_w + (UW'(n2_w) << (UN_STEPS - i));
            un_q_r[i][j]   <= q_w | (UN_BITS'(1) << (UN_STEPS - 1 - i));
          end else begin
            un_rem_r[i][j] <= rem_w;
            un_p_r[i][j]   <= p_w;
            un_q_r[i][j]   <= q_w;
          end
        end
      end
    end
  end

  un_res_t un_dly_r [UN_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      un_dly_r[0] <= '{qx: un_q_r[UN_STEPS-1][0], qy: un_q_r[UN_STEPS-1][1],
                       x_neg: un_neg_r[UN_STEPS-1][0], y_neg: un_neg_r[UN_STEPS-1][1]};
      for (int k = 1; k < UN_DLY; k++) begin
        un_dly_r[k] <= un_dly_r[k-1];
      end
    end
  end

  // Crossing point: S plus the signed, rounded offset.
  side_t                 sd_w;
  logic signed [CW+1:0]  offx_w, offy_w, px_w, py_w;
  logic signed [CW-1:0]  p4_px_r, p4_py_r, p4_fr_r;
  side_t                 p4_sd_r;

  assign sd_w   = side_dly_r[MD_LAT-1];
  assign offx_w = sd_w.dx_neg ? -(CW+2)'(qx_w) : (CW+2)'(qx_w);
  assign offy_w = sd_w.dy_neg ? -(CW+2)'(qy_w) : (CW+2)'(qy_w);
  assign px_w   = (CW+2)'(sd_w.sx) + offx_w;
  assign py_w   = (CW+2)'(sd_w.sy) + offy_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_px_r <= px_w[CW-1:0];
      p4_py_r <= py_w[CW-1:0];
      p4_fr_r <= qf_w[CW-1:0];
      p4_sd_r <= sd_w;
    end
  end

  // Projection of the crossing point onto the wall.
  logic signed [DFW-1:0] p5_pax_r, p5_pay_r, p5_bpx_r, p5_bpy_r, p5_nx_r, p5_ny_r;
  logic signed [CW-1:0]  p5_px_r, p5_py_r, p5_fr_r;
  logic                  p5_keep_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_pax_r  <= ext_c(p4_px_r) - ext_c(p4_sd_r.ax);
      p5_pay_r  <= ext_c(p4_py_r) - ext_c(p4_sd_r.ay);
      p5_bpx_r  <= ext_c(p4_sd_r.bx) - ext_c(p4_px_r);
      p5_bpy_r  <= ext_c(p4_sd_r.by) - ext_c(p4_py_r);
      p5_nx_r   <= p4_sd_r.nx;
      p5_ny_r   <= p4_sd_r.ny;
      p5_px_r   <= p4_px_r;
      p5_py_r   <= p4_py_r;
      p5_fr_r   <= p4_fr_r;
      p5_keep_r <= p4_sd_r.keep;
    end
  end

  logic signed [PW-1:0] p6_aa_r, p6_ab_r, p6_ba_r, p6_bb_r;
  logic signed [CW-1:0] p6_px_r, p6_py_r, p6_fr_r;
  logic                 p6_keep_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_aa_r   <= p5_pax_r * p5_ny_r;
      p6_ab_r   <= p5_pay_r * p5_nx_r;
      p6_ba_r   <= p5_bpx_r * p5_ny_r;
      p6_bb_r   <= p5_bpy_r * p5_nx_r;
      p6_px_r   <= p5_px_r;
      p6_py_r   <= p5_py_r;
      p6_fr_r   <= p5_fr_r;
      p6_keep_r <= p5_keep_r;
    end
  end

  // Output stage: final decision, zero every field on a miss.
  logic signed [SW-1:0] dot_a_w, dot_b_w;
  logic                 hit_w;
  un_res_t              un_w;
  out_word_t            out_r;

  assign dot_a_w = SW'(p6_aa_r) - SW'(p6_ab_r);
  assign dot_b_w = SW'(p6_ba_r) - SW'(p6_bb_r);
  assign hit_w   = p6_keep_r && !dot_a_w[SW-1] && !dot_b_w[SW-1];
  assign un_w    = un_dly_r[UN_DLY-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.hit <= hit_w;
      if (hit_w) begin
        out_r.cross_x       <= p6_px_r;
        out_r.cross_y       <= p6_py_r;
        out_r.fraction      <= p6_fr_r;
        out_r.unit_normal_x <= un_w.x_neg ? -NOW'(un_w.qx) : NOW'(un_w.qx);
        out_r.unit_normal_y <= un_w.y_neg ? -NOW'(un_w.qy) : NOW'(un_w.qy);
      end else begin
        out_r.cross_x       <= '0;
        out_r.cross_y       <= '0;
        out_r.fraction      <= '0;
        out_r.unit_normal_x <= '0;
        out_r.unit_normal_y <= '0;
      end
    end
  end

  assign out_ch.valid = v_r[NST-1];
  assign out_ch.data  = out_r;

endmodule
`default_nettype wire

### rtl/dsc_checker.sv
// Port-level checks for the segment crossing block, bound to the top level.
`default_nettype none
module dsc_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire dsc_pkg::out_word_t   out_data
);
  import dsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.cross_x == '0 && out_data.cross_y == '0
      && out_data.fraction == '0 && out_data.unit_normal_x == '0
      && out_data.unit_normal_y == '0)
    else $error("miss word carries non-zero fields");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.unit_normal_x <= 16'sd16384
      && out_data.unit_normal_x >= -16'sd16384 && out_data.unit_normal_y <= 16'sd16384
      && out_data.unit_normal_y >= -16'sd16384)
    else $error("unit normal out of range");

endmodule

bind directed_segment_crossing_test_top dsc_checker u_dsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

### tb/directed_segment_crossing_test_checker.sv
// Checker for the segment crossing test: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module directed_segment_crossing_test_checker #(
  parameter int FRAC_BITS = dsc_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dsc_in_if    in_ch,
  dsc_out_if   out_ch,
  output int   fails,
  output int   pending
);
  import dsc_pkg::*;

  typedef logic signed [127:0] wide_t;

  out_word_t crossings_due[$];

  // round half up for positive numerator and denominator
  function automatic wide_t div_nearest(wide_t num, wide_t den);
    return ((num <<< 1) + den) / (den <<< 1);
  endfunction

  function automatic wide_t abs_w(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // largest q <= 16384 with (2q-1)^2 * n2 <= c^2 * 2^30, signed like c
  function automatic logic signed [NOW-1:0] unit_of(wide_t c, wide_t n2);
    wide_t rhs, q, cand, odd;
    rhs = (abs_w(c) * abs_w(c)) <<< 30;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = q | (wide_t'(1) <<< b);
      odd = 2 * cand - 1;
      if (cand <= 16384 && rhs >= n2 * odd * odd) q = cand;
    end
    return NOW'(c < 0 ? -q : q);
  endfunction

  function automatic out_word_t crossing_of(in_word_t w);
    out_word_t r;
    wide_t sx, sy, ex, ey, ax, ay, bx, by, nx, ny, wx, wy;
    wide_t d1, d2, den, px, py, frac, dx, dy;
    r = '0;
    sx = wide_t'(w.start_x);  sy = wide_t'(w.start_y);
    ex = wide_t'(w.end_x);    ey = wide_t'(w.end_y);
    ax = wide_t'(w.wall_a_x); ay = wide_t'(w.wall_a_y);
    bx = wide_t'(w.wall_b_x); by = wide_t'(w.wall_b_y);
    nx = ay - by; ny = bx - ax;
    wx = bx - ax; wy = by - ay;
    d1 = nx * (sx - ax) + ny * (sy - ay);
    d2 = nx * (ex - ax) + ny * (ey - ay);
    if (d1 < 0) return r;
    if (d1 > 0 && d2 > 0) return r;
    if (d1 == d2) return r;
    if (d1 == 0) begin
      frac = 0; px = sx; py = sy;
    end else begin
      den = d1 - d2;
      frac = div_nearest(d1 <<< FRAC_BITS, den);
      dx = ex - sx; dy = ey - sy;
      px = div_nearest(d1 * abs_w(dx), den);
      py = div_nearest(d1 * abs_w(dy), den);
      px = sx + (dx < 0 ? -px : px);
      py = sy + (dy < 0 ? -py : py);
    end
    if ((px - ax) * wx + (py - ay) * wy < 0) return r;
    if ((px - bx) * -wx + (py - by) * -wy < 0) return r;
    if ((ex - ax) * wx + (ey - ay) * wy < 0) return r;
    if ((ex - bx) * -wx + (ey - by) * -wy < 0) return r;
    r.hit = 1'b1;
    r.cross_x = CW'(px);
    r.cross_y = CW'(py);
    r.fraction = CW'(frac);
    r.unit_normal_x = unit_of(nx, nx * nx + ny * ny);
    r.unit_normal_y = unit_of(ny, nx * nx + ny * ny);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_word_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) crossings_due.push_back(crossing_of(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (crossings_due.size() == 0) begin
          report_mismatch("unexpected word", 64'(got.hit), 64'(0));
        end else begin
          want = crossings_due.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.cross_x !== want.cross_x)
            report_mismatch("cross_x", 64'(got.cross_x), 64'(want.cross_x));
          if (got.cross_y !== want.cross_y)
            report_mismatch("cross_y", 64'(got.cross_y), 64'(want.cross_y));
          if (got.fraction !== want.fraction)
            report_mismatch("fraction", 64'(got.fraction), 64'(want.fraction));
          if (got.unit_normal_x !== want.unit_normal_x)
            report_mismatch("unit_normal_x", 64'(got.unit_normal_x), 64'(want.unit_normal_x));
          if (got.unit_normal_y !== want.unit_normal_y)
            report_mismatch("unit_normal_y", 64'(got.unit_normal_y), 64'(want.unit_normal_y));
        end
      end
      pending <= crossings_due.size();
    end
  end

endmodule

### tb/directed_segment_crossing_test_top_test.sv
// Testbench top: clock, reset, segment stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module directed_segment_crossing_test_top_test;
  import dsc_pkg::*;

  localparam int N_RANDOM = 1900;
  localparam int MAX_INT = 32'sh7fffffff;
  localparam int MIN_INT = 32'sh80000000;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   tx_idle;
  int   rx_idle;
  logic stall_req;
  logic stall_done;
  int   stall_left;

  dsc_in_if  in_ch ();
  dsc_out_if out_ch ();

  directed_segment_crossing_test_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  directed_segment_crossing_test_checker chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .fails  (fails),
    .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: random stalls, plus one long hold-off so the pipe fills
  always @(posedge clk) begin
    if (stall_req && !stall_done) begin
      stall_left <= 300;
      stall_done <= 1'b1;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic in_word_t seg(int sx, int sy, int ex, int ey,
                                   int ax, int ay, int bx, int by);
    in_word_t w;
    w.start_x = sx;  w.start_y = sy;  w.end_x = ex;    w.end_y = ey;
    w.wall_a_x = ax; w.wall_a_y = ay; w.wall_b_x = bx; w.wall_b_y = by;
    return w;
  endfunction

  // wall A..A+16w; start in front, end behind, both over the wall, then maybe spoil it
  function automatic in_word_t crossing_pair();
    int ax, ay, wx, wy, u1, u2, a, c, sh;
    in_word_t w;
    sh = $urandom_range(0, 3) * 4;
    ax = int'($urandom_range(0, 1 << 29)) - (1 << 28);
    ay = int'($urandom_range(0, 1 << 29)) - (1 << 28);
    wx = (int'($urandom_range(0, 8192)) - 4096) >>> sh;
    wy = (int'($urandom_range(0, 8192)) - 4096) >>> sh;
    u1 = $urandom_range(0, 16);
    u2 = $urandom_range(0, 16);
    a = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 4096) >> sh;
    c = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 4096) >> sh;
    w = seg(ax + u1 * wx - a * wy, ay + u1 * wy + a * wx,
            ax + u2 * wx + c * wy, ay + u2 * wy - c * wx,
            ax, ay, ax + 16 * wx, ay + 16 * wy);
    case ($urandom_range(0, 9))
      0: w = seg(w.end_x, w.end_y, w.start_x, w.start_y,
                 w.wall_a_x, w.wall_a_y, w.wall_b_x, w.wall_b_y);
      1: begin
        w.end_x = w.end_x + 20 * wx;
        w.end_y = w.end_y + 20 * wy;
      end
      2: begin
        w.wall_b_x = w.wall_a_x;
        w.wall_b_y = w.wall_a_y;
      end
      3: w = seg($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      default: ;
    endcase
    return w;
  endfunction

  task automatic send(in_word_t w);
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    stall_req = 1'b0;
    stall_done = 1'b0;
    stall_left = 0;
    tx_idle = 9;
    rx_idle = 64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // simple hit across a vertical wall, and its reverse (from behind)
    send(seg(-65536, 0, 65536, 0, 0, -65536, 0, 65536));
    send(seg(65536, 0, -65536, 0, 0, -65536, 0, 65536));
    // start on the wall with the end in front and behind
    send(seg(0, 0, 65536, 0, 0, -65536, 0, 65536));
    send(seg(0, 0, -65536, 0, 0, -65536, 0, 65536));
    // end on the wall
    send(seg(-65536, 32768, 0, 32768, 0, -65536, 0, 65536));
    // degenerate wall, collinear motion
    send(seg(-65536, 0, 65536, 0, 5, 5, 5, 5));
    send(seg(0, -65536, 0, 65536, 0, -65536, 0, 65536));
    // end projects past the wall end, crossing on the vertex
    send(seg(-65536, 0, 65536, 196608, 0, -65536, 0, 65536));
    send(seg(-65536, 65536, 65536, 65536, 0, -65536, 0, 65536));
    // diagonal wall and odd fractions
    send(seg(-3, 7, 11, -5, -100000, -90000, 123457, 98765));
    send(seg(-1, 0, 2, 0, 0, -1, 0, 1));
    // field extremes
    send(seg(MAX_INT, MAX_INT, MAX_INT, MAX_INT, MAX_INT, MAX_INT, MAX_INT, MAX_INT));
    send(seg(MIN_INT, MIN_INT, MIN_INT, MIN_INT, MIN_INT, MIN_INT, MIN_INT, MIN_INT));
    send(seg(MIN_INT, 0, MAX_INT, 0, 0, MIN_INT, 0, MAX_INT));
    send(seg(MAX_INT, 0, MIN_INT, 0, 0, MAX_INT, 0, MIN_INT));
    send(seg(MIN_INT, MIN_INT, MAX_INT, MAX_INT, MAX_INT, MIN_INT, MIN_INT, MAX_INT));
    send(seg(-1, -1, -1, -1, -1, -1, -1, -1));
    send(seg(0, 0, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        tx_idle = 64;
        rx_idle = 9;
      end else if (i == 2 * N_RANDOM / 3) begin
        tx_idle = 0;
        rx_idle = 0;
        stall_req = 1'b1;
      end
      send(crossing_pair());
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("directed_segment_crossing_test_top test passed");
    end else begin
      $display("directed_segment_crossing_test_top test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("directed_segment_crossing_test_top test failed");
    $finish;
  end

endmodule
